// ----- design/digitizer_block_word_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the readout word parser
// Assertions sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DIGITIZER_BLOCK_WORD_PARSER_DEFINES_SVH
`define DIGITIZER_BLOCK_WORD_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define DBWP_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define DBWP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DBWP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DBWP_ASSERT(label, expr, msg)
`define DBWP_ASSERT_IMP(label, ante, cons, msg)
`define DBWP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ----- design/dbwp_pkg.sv -----
// ----------------------------------------------------------------------------
// dbwp_pkg
// Types and codes shared by the readout word parser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dbwp_pkg;

    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_ROC_ID      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_EVENT = 2'd1;

    localparam logic [3:0] TYPE_BLOCK_HEADER  = 4'd0;
    localparam logic [3:0] TYPE_BLOCK_TRAILER = 4'd1;
    localparam logic [3:0] TYPE_EVENT_HEADER  = 4'd2;
    localparam logic [3:0] TYPE_TRIGGER_TIME  = 4'd3;
    localparam logic [3:0] TYPE_FRAME_HEADER  = 4'd5;

    typedef enum logic [2:0] {
        KIND_HIT           = 3'd0,
        KIND_EVENT_MISMATCH = 3'd1,
        KIND_TRAILER_EARLY = 3'd2,
        KIND_TRAILER_SLOT  = 3'd3,
        KIND_EVENT_EARLY   = 3'd4,
        KIND_TIME_EARLY    = 3'd5,
        KIND_FRAME_EARLY   = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        OP_DATA          = 3'd0,
        OP_BLOCK_HEADER  = 3'd1,
        OP_BLOCK_TRAILER = 3'd2,
        OP_EVENT_HEADER  = 3'd3,
        OP_TRIGGER_TIME  = 3'd4,
        OP_FRAME_HEADER  = 3'd5,
        OP_OTHER         = 3'd6
    } opcode_t;

    typedef struct packed {
        opcode_t     op;
        logic [31:0] word;
    } entry_t;

    typedef struct packed {
        logic [7:0]  roc_id;
        logic [31:0] first_event;
    } cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  roc_id_out;
        logic [4:0]  slot;
        logic [31:0] event_num;
        logic [47:0] trig_stamp;
        logic [4:0]  fiber_num;
        logic [4:0]  module_id;
        logic [4:0]  chip_id;
        logic [9:0]  channel;
        logic [38:0] samples_first_three;
        logic [38:0] samples_last_three;
    } result_t;

endpackage

`default_nettype wire

// ----- design/dbwp_if.sv -----
// ----------------------------------------------------------------------------
// dbwp interfaces
// Valid/ready channels for configuration writes, readout words and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dbwp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [dbwp_pkg::CFG_INDEX_W-1:0]    index;
    logic [31:0]                         data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface dbwp_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] word;

    modport source (output valid, word, input ready);
    modport sink   (input valid, word, output ready);
endinterface

interface dbwp_result_if;
    logic                  valid;
    logic                  ready;
    dbwp_pkg::kind_t       kind;
    logic [7:0]            roc_id_out;
    logic [4:0]            slot;
    logic [31:0]           event_num;
    logic [47:0]           trig_stamp;
    logic [4:0]            fiber_num;
    logic [4:0]            module_id;
    logic [4:0]            chip_id;
    logic [9:0]            channel;
    logic [38:0]           samples_first_three;
    logic [38:0]           samples_last_three;

    modport source (output valid, kind, roc_id_out, slot, event_num, trig_stamp,
                    fiber_num, module_id, chip_id, channel, samples_first_three,
                    samples_last_three, input ready);
    modport sink   (input valid, kind, roc_id_out, slot, event_num, trig_stamp,
                    fiber_num, module_id, chip_id, channel, samples_first_three,
                    samples_last_three, output ready);
endinterface

`default_nettype wire

// ----- design/dbwp_front.sv -----
// ----------------------------------------------------------------------------
// dbwp_front
// Accepts readout words, decodes the word type and hands entries to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dbwp_front
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    dbwp_word_if.sink             words,
    output dbwp_pkg::entry_t      push_entry,
    output logic                  push_valid,
    input  wire logic             push_ready
);

    logic              hold_valid_reg;
    logic              hold_valid_next;
    dbwp_pkg::entry_t  hold_entry_reg;
    dbwp_pkg::opcode_t op_decoded;
    logic              take;

    assign words.ready = !hold_valid_reg || push_ready;
    assign take        = words.valid && words.ready;
    assign push_valid  = hold_valid_reg;
    assign push_entry  = hold_entry_reg;

    always_comb
    begin
        if (!words.word[31])
        begin
            op_decoded = dbwp_pkg::OP_DATA;
        end
        else
        begin
            unique case (words.word[30:27])
                dbwp_pkg::TYPE_BLOCK_HEADER:  op_decoded = dbwp_pkg::OP_BLOCK_HEADER;
                dbwp_pkg::TYPE_BLOCK_TRAILER: op_decoded = dbwp_pkg::OP_BLOCK_TRAILER;
                dbwp_pkg::TYPE_EVENT_HEADER:  op_decoded = dbwp_pkg::OP_EVENT_HEADER;
                dbwp_pkg::TYPE_TRIGGER_TIME:  op_decoded = dbwp_pkg::OP_TRIGGER_TIME;
                dbwp_pkg::TYPE_FRAME_HEADER:  op_decoded = dbwp_pkg::OP_FRAME_HEADER;
                default:                      op_decoded = dbwp_pkg::OP_OTHER;
            endcase
        end
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_entry_reg.op   <= op_decoded;
            hold_entry_reg.word <= words.word;
        end
    end

endmodule

`default_nettype wire

// ----- design/dbwp_queue.sv -----
// ----------------------------------------------------------------------------
// dbwp_queue
// Short FIFO of decoded entries between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "digitizer_block_word_parser_defines.svh"

module dbwp_queue
#(
    parameter int DEPTH = 2
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dbwp_pkg::entry_t  push_entry,
    input  wire logic              push_valid,
    output logic                   push_ready,
    output dbwp_pkg::entry_t       pop_entry,
    output logic                   pop_valid,
    input  wire logic              pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dbwp_pkg::entry_t  slots_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `DBWP_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")
    `DBWP_ASSERT_IMP(a_pop_nonempty, pop, pop_valid, "pop from empty queue")
    `DBWP_ASSERT_NEXT(a_count_up, push && !do_pop,
        count_reg == $past(count_reg) + CNT_W'(1), "queue count did not advance on push")

endmodule

`default_nettype wire

// ----- design/dbwp_back.sv -----
// ----------------------------------------------------------------------------
// dbwp_back
// Executes decoded entries against the block and event state and registers
// the hit or error result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "digitizer_block_word_parser_defines.svh"

module dbwp_back
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dbwp_pkg::cfg_t    cfg_regs,
    input  wire dbwp_pkg::entry_t  pop_entry,
    input  wire logic              pop_valid,
    output logic                   pop,
    dbwp_result_if.source          results
);

    logic               block_open_reg,  block_open_next;
    logic [7:0]         events_left_reg, events_left_next;
    logic [4:0]         block_slot_reg,  block_slot_next;
    logic [31:0]        event_index_reg, event_index_next;
    logic [31:0]        current_event_reg, current_event_next;
    logic [47:0]        timestamp_reg,   timestamp_next;
    logic [23:0]        time_low_reg,    time_low_next;
    logic               await_high_reg,  await_high_next;
    logic               in_frame_reg,    in_frame_next;
    logic [4:0]         fiber_reg,       fiber_next;
    logic [4:0]         module_reg,      module_next;
    logic [1:0]         phase_reg,       phase_next;
    logic [9:0]         channel_reg,     channel_next;
    logic [12:0]        held_samples_reg  [4];
    logic [12:0]        held_samples_next [4];

    logic               out_valid_reg;
    dbwp_pkg::result_t  result_reg;
    dbwp_pkg::result_t  result_next;
    logic               fire;
    logic               err;
    dbwp_pkg::kind_t    err_kind;
    logic [31:0]        w;

    assign pop = pop_valid && (!out_valid_reg || results.ready);
    assign w   = pop_entry.word;

    always_comb
    begin
        block_open_next    = block_open_reg;
        events_left_next   = events_left_reg;
        block_slot_next    = block_slot_reg;
        event_index_next   = event_index_reg;
        current_event_next = current_event_reg;
        timestamp_next     = timestamp_reg;
        time_low_next      = time_low_reg;
        await_high_next    = await_high_reg;
        in_frame_next      = in_frame_reg;
        fiber_next         = fiber_reg;
        module_next        = module_reg;
        phase_next         = phase_reg;
        channel_next       = channel_reg;
        held_samples_next  = held_samples_reg;
        fire               = 1'b0;
        err                = 1'b0;
        err_kind           = dbwp_pkg::KIND_TRAILER_EARLY;

        result_next            = '0;
        result_next.kind       = dbwp_pkg::KIND_HIT;
        result_next.roc_id_out = cfg_regs.roc_id;
        result_next.slot       = block_slot_reg;
        result_next.event_num  = current_event_reg;

        if (pop)
        begin
            if (await_high_reg)
            begin
                await_high_next = 1'b0;
                timestamp_next  = {w[23:0], time_low_reg};
            end
            else if (in_frame_reg && (phase_reg != 2'd0 || pop_entry.op == dbwp_pkg::OP_DATA))
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        channel_next         = {5'd0, w[30:26]};
                        held_samples_next[0] = w[12:0];
                        held_samples_next[1] = w[25:13];
                        phase_next           = 2'd1;
                    end
                    2'd1:
                    begin
                        channel_next         = {w[30:26], channel_reg[4:0]};
                        held_samples_next[2] = w[12:0];
                        held_samples_next[3] = w[25:13];
                        phase_next           = 2'd2;
                    end
                    default:
                    begin
                        phase_next                      = 2'd0;
                        fire                            = 1'b1;
                        result_next.trig_stamp          = timestamp_reg;
                        result_next.fiber_num           = fiber_reg;
                        result_next.module_id           = module_reg;
                        result_next.chip_id             = w[30:26];
                        result_next.channel             = channel_reg;
                        result_next.samples_first_three = {held_samples_reg[2],
                                                           held_samples_reg[1],
                                                           held_samples_reg[0]};
                        result_next.samples_last_three  = {w[25:13], w[12:0],
                                                           held_samples_reg[3]};
                    end
                endcase
            end
            else if (pop_entry.op != dbwp_pkg::OP_DATA)
            begin
                in_frame_next = 1'b0;
                phase_next    = 2'd0;
                unique case (pop_entry.op)
                    dbwp_pkg::OP_BLOCK_HEADER:
                    begin
                        block_slot_next  = w[26:22];
                        events_left_next = w[7:0];
                        block_open_next  = 1'b1;
                    end
                    dbwp_pkg::OP_BLOCK_TRAILER:
                    begin
                        if (!block_open_reg || events_left_reg != 8'd0)
                        begin
                            err      = 1'b1;
                            err_kind = dbwp_pkg::KIND_TRAILER_EARLY;
                        end
                        else if (w[26:22] != block_slot_reg)
                        begin
                            err      = 1'b1;
                            err_kind = dbwp_pkg::KIND_TRAILER_SLOT;
                        end
                        else
                        begin
                            block_open_next  = 1'b0;
                            event_index_next = '0;
                        end
                    end
                    dbwp_pkg::OP_EVENT_HEADER:
                    begin
                        if (!block_open_reg || events_left_reg == 8'd0)
                        begin
                            err      = 1'b1;
                            err_kind = dbwp_pkg::KIND_EVENT_EARLY;
                        end
                        else
                        begin
                            events_left_next   = events_left_reg - 8'd1;
                            current_event_next = cfg_regs.first_event + event_index_reg;
                            event_index_next   = event_index_reg + 32'd1;
                            if (current_event_next != {16'd0, w[15:0]})
                            begin
                                fire                  = 1'b1;
                                result_next.kind      = dbwp_pkg::KIND_EVENT_MISMATCH;
                                result_next.event_num = current_event_next;
                            end
                        end
                    end
                    dbwp_pkg::OP_TRIGGER_TIME:
                    begin
                        if (!block_open_reg)
                        begin
                            err      = 1'b1;
                            err_kind = dbwp_pkg::KIND_TIME_EARLY;
                        end
                        else
                        begin
                            time_low_next   = w[23:0];
                            await_high_next = 1'b1;
                        end
                    end
                    dbwp_pkg::OP_FRAME_HEADER:
                    begin
                        if (!block_open_reg)
                        begin
                            err      = 1'b1;
                            err_kind = dbwp_pkg::KIND_FRAME_EARLY;
                        end
                        else
                        begin
                            fiber_next    = w[20:16];
                            module_next   = w[4:0];
                            in_frame_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (err)
                begin
                    fire             = 1'b1;
                    result_next.kind = err_kind;
                    block_open_next  = 1'b0;
                    events_left_next = '0;
                    event_index_next = '0;
                    in_frame_next    = 1'b0;
                    phase_next       = 2'd0;
                    await_high_next  = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_open_reg    <= 1'b0;
            events_left_reg   <= '0;
            block_slot_reg    <= '0;
            event_index_reg   <= '0;
            current_event_reg <= '0;
            timestamp_reg     <= '0;
            time_low_reg      <= '0;
            await_high_reg    <= 1'b0;
            in_frame_reg      <= 1'b0;
            fiber_reg         <= '0;
            module_reg        <= '0;
            phase_reg         <= '0;
            channel_reg       <= '0;
            for (int i = 0; i < 4; i++)
            begin
                held_samples_reg[i] <= '0;
            end
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            block_open_reg    <= block_open_next;
            events_left_reg   <= events_left_next;
            block_slot_reg    <= block_slot_next;
            event_index_reg   <= event_index_next;
            current_event_reg <= current_event_next;
            timestamp_reg     <= timestamp_next;
            time_low_reg      <= time_low_next;
            await_high_reg    <= await_high_next;
            in_frame_reg      <= in_frame_next;
            fiber_reg         <= fiber_next;
            module_reg        <= module_next;
            phase_reg         <= phase_next;
            channel_reg       <= channel_next;
            held_samples_reg  <= held_samples_next;
            if (pop)
            begin
                out_valid_reg <= fire;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && fire)
        begin
            result_reg <= result_next;
        end
    end

    assign results.valid               = out_valid_reg;
    assign results.kind                = result_reg.kind;
    assign results.roc_id_out          = result_reg.roc_id_out;
    assign results.slot                = result_reg.slot;
    assign results.event_num           = result_reg.event_num;
    assign results.trig_stamp          = result_reg.trig_stamp;
    assign results.fiber_num           = result_reg.fiber_num;
    assign results.module_id           = result_reg.module_id;
    assign results.chip_id             = result_reg.chip_id;
    assign results.channel             = result_reg.channel;
    assign results.samples_first_three = result_reg.samples_first_three;
    assign results.samples_last_three  = result_reg.samples_last_three;

    `DBWP_ASSERT(a_phase_range, phase_reg != 2'd3, "sample group phase out of range")
    `DBWP_ASSERT_IMP(a_phase_in_frame, !in_frame_reg, phase_reg == 2'd0,
        "sample group open outside a frame")
    `DBWP_ASSERT_IMP(a_await_in_block, await_high_reg, block_open_reg,
        "trigger time pending with no open block")
    `DBWP_ASSERT_IMP(a_no_pop_stalled, out_valid_reg && !results.ready, !pop,
        "entry retired while result stalled")

endmodule

`default_nettype wire

// ----- design/digitizer_block_word_parser.sv -----
// ----------------------------------------------------------------------------
// digitizer_block_word_parser
// Readout word parser: block, event, trigger time and frame decode with hit
// assembly from sample word triplets.
// ----------------------------------------------------------------------------
// The block takes one readout word per cycle on words and sustains that rate
// while results are taken; the back end retires one queued word per cycle,
// which sets the throughput. A result (hit or error report) becomes valid on
// results after the word that caused it has passed the front decode register
// and the queue; it then waits in the output register until its transfer.
// Configuration writes are always accepted and must be issued only while the
// parser is idle.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module digitizer_block_word_parser
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    dbwp_cfg_if.sink      cfg,
    dbwp_word_if.sink     words,
    dbwp_result_if.source results
);

    dbwp_pkg::cfg_t    cfg_regs_reg;
    dbwp_pkg::entry_t  push_entry;
    logic              push_valid;
    logic              push_ready;
    dbwp_pkg::entry_t  pop_entry;
    logic              pop_valid;
    logic              pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                dbwp_pkg::REG_ROC_ID:      cfg_regs_reg.roc_id      <= cfg.data[7:0];
                dbwp_pkg::REG_FIRST_EVENT: cfg_regs_reg.first_event <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    dbwp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    dbwp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop        (pop)
    );

    dbwp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_regs  (cfg_regs_reg),
        .pop_entry (pop_entry),
        .pop_valid (pop_valid),
        .pop       (pop),
        .results   (results)
    );

endmodule

`default_nettype wire
